@@ rtl/gapbuf_pkg.sv @@
// Shared types and constants for the gap-buffer line editor.
// Depends on nothing; the core refers to it by scoped names.
`default_nettype none

package gapbuf_pkg;

	// Store size; must stay a power of two so store indexes wrap modulo CAPACITY
	localparam int CAPACITY = 1024;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CHAR_W   = 8;

	// Action codes
	localparam logic [2:0] ACT_INSERT    = 3'd0;
	localparam logic [2:0] ACT_LEFT      = 3'd1;
	localparam logic [2:0] ACT_RIGHT     = 3'd2;
	localparam logic [2:0] ACT_BACKSPACE = 3'd3;
	localparam logic [2:0] ACT_READ      = 3'd4;

	// Status codes
	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_BOUNDARY = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_RANGE    = 2'd3;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  char_value;
		logic [9:0]  position;
	} req_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  read_char;
		logic [10:0] text_length;
		logic [10:0] cursor_pos;
	} rsp_item_t;

endpackage

`default_nettype wire

@@ rtl/gapbuf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module gapbuf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port: hold data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/cursor_text_gap_buffer_core.sv @@
// Gap-buffer line editor: cursor count registers around one text RAM.
// Depends on gapbuf_pkg and gapbuf_ram.
//
// Usage:
//   Request channel (req_valid / req_stall / req) carries one action per item:
//   insert, cursor left, cursor right, backspace or read position.
//   Response channel (rsp_valid / rsp_stall / rsp) returns exactly one item per
//   request with status, read character, text length and cursor position.
//   Each item is accepted in S_IDLE, where the RAM read is issued; in S_RD it
//   uses the registered RAM data, writes the RAM (insert, or the byte that a
//   cursor move carries across the gap) and loads the response register.
//   The registered read data of the text RAM is why an item needs S_RD; a new
//   request is not taken until the current item finishes, as req_stall is high
//   in S_RD. rsp_valid rises at the edge that finishes the item and loads the
//   response register.
//   The response register lets the next request be accepted while an earlier
//   response waits; if rsp_stall holds the register full, the finishing item
//   waits in S_RD and req_stall stays high until the slot frees.
//   Reset clears the cursor counts and handshake state; the text RAM is not
//   cleared, which needs no pass since data read from unwritten entries is never used.
`default_nettype none

module cursor_text_gap_buffer_core (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output      logic                  req_stall,
	input  wire gapbuf_pkg::req_item_t req,
	output      logic                  rsp_valid,
	input  wire logic                  rsp_stall,
	output      gapbuf_pkg::rsp_item_t rsp
);

	localparam int AW = gapbuf_pkg::ADDR_W;
	localparam int CW = gapbuf_pkg::CNT_W;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RD   = 1'b1;

	logic          state_q;
	logic [CW-1:0] left_q;
	logic [CW-1:0] right_q;

	logic [2:0]    act_s1;
	logic [1:0]    status_s1;
	logic [7:0]    char_s1;

	logic          rsp_valid_q;
	gapbuf_pkg::rsp_item_t rsp_q;

	logic          accept;
	logic          slot_free;
	logic          finish;
	logic [CW-1:0] len;
	logic [AW-1:0] left_a;
	logic [AW-1:0] right_a;
	logic [AW-1:0] raddr;
	logic [1:0]    status_d;
	logic          ok;
	logic [CW-1:0] left_d;
	logic [CW-1:0] right_d;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;
	logic [7:0]    rdata;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign finish    = (state_q == S_RD) && slot_free;

	assign len     = left_q + right_q;
	assign left_a  = left_q[AW-1:0];
	assign right_a = right_q[AW-1:0];

	// Pick the read index and decide the status from the current counts
	always_comb begin
		raddr    = req.position;
		status_d = gapbuf_pkg::ST_DONE;
		case (req.action)
			gapbuf_pkg::ACT_INSERT: begin
				if (len >= CW'(gapbuf_pkg::CAPACITY)) begin
					status_d = gapbuf_pkg::ST_FULL;
				end
			end
			gapbuf_pkg::ACT_LEFT: begin
				raddr = left_a - AW'(1);
				if (left_q == '0) begin
					status_d = gapbuf_pkg::ST_BOUNDARY;
				end
			end
			gapbuf_pkg::ACT_RIGHT: begin
				// first byte right of the gap sits at CAPACITY - right_count
				raddr = AW'(0) - right_a;
				if (right_q == '0) begin
					status_d = gapbuf_pkg::ST_BOUNDARY;
				end
			end
			gapbuf_pkg::ACT_BACKSPACE: begin
				if (left_q == '0) begin
					status_d = gapbuf_pkg::ST_BOUNDARY;
				end
			end
			gapbuf_pkg::ACT_READ: begin
				// right of the cursor, skip the gap: pos - left - right mod CAPACITY
				if ({1'b0, req.position} >= len) begin
					status_d = gapbuf_pkg::ST_RANGE;
				end else if ({1'b0, req.position} >= left_q) begin
					raddr = req.position - left_a - right_a;
				end
			end
			default: begin
				status_d = gapbuf_pkg::ST_BOUNDARY;
			end
		endcase
	end

	// Latch the item for use in S_RD
	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1    <= req.action;
			status_s1 <= status_d;
			char_s1   <= req.char_value;
		end
	end

	assign ok = (status_s1 == gapbuf_pkg::ST_DONE);

	// Work out the new counts and the write-back
	always_comb begin
		left_d  = left_q;
		right_d = right_q;
		waddr   = left_a;
		wdata   = rdata;
		we      = 1'b0;
		case (act_s1)
			gapbuf_pkg::ACT_INSERT: begin
				wdata  = char_s1;
				we     = ok;
				left_d = ok ? left_q + CW'(1) : left_q;
			end
			gapbuf_pkg::ACT_LEFT: begin
				waddr   = ~right_a;
				we      = ok;
				left_d  = ok ? left_q - CW'(1) : left_q;
				right_d = ok ? right_q + CW'(1) : right_q;
			end
			gapbuf_pkg::ACT_RIGHT: begin
				we      = ok;
				left_d  = ok ? left_q + CW'(1) : left_q;
				right_d = ok ? right_q - CW'(1) : right_q;
			end
			gapbuf_pkg::ACT_BACKSPACE: begin
				left_d = ok ? left_q - CW'(1) : left_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	gapbuf_ram #(
		.WIDTH(gapbuf_pkg::CHAR_W),
		.DEPTH(gapbuf_pkg::CAPACITY)
	) u_text_ram (
		.clk   (clk),
		.we    (we && finish),
		.waddr (waddr),
		.wdata (wdata),
		.re    (accept),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Sequence S_IDLE and S_RD and commit the counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			left_q  <= '0;
			right_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (finish) begin
						state_q <= S_IDLE;
						left_q  <= left_d;
						right_q <= right_d;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Response register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_q.status      <= status_s1;
			rsp_q.read_char   <= (act_s1 == gapbuf_pkg::ACT_READ && ok) ? rdata : 8'd0;
			rsp_q.text_length <= left_d + right_d;
			rsp_q.cursor_pos  <= left_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(len <= CW'(gapbuf_pkg::CAPACITY)))
		else $error("text length exceeds capacity");

	a_accept_to_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == S_RD))
		else $error("accepted item did not reach its second cycle");

	a_counts_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |=> ($stable(left_q) && $stable(right_q)))
		else $error("counts changed outside item completion");

	a_finish_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> rsp_valid)
		else $error("finished item produced no response");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == gapbuf_pkg::ST_FULL)
		|-> (rsp.text_length == CW'(gapbuf_pkg::CAPACITY)))
		else $error("full status with buffer not full");
`endif

endmodule

`default_nettype wire
